[rtl/core/assert_macros.svh]
// Assertion helpers, sampled on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define A_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define A_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define A_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/gts_pkg.sv]
package gts_pkg;

	localparam int GRADIENT_SPAN = 100;
	localparam int OUTPUT_DELAY  = 1024;
	localparam int STORE_DEPTH   = (OUTPUT_DELAY > GRADIENT_SPAN) ? OUTPUT_DELAY : GRADIENT_SPAN;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int PTR_W         = ADDR_W + 1;
	localparam int FILL_W        = $clog2(STORE_DEPTH + 1);
	localparam int OLD_OFS       = STORE_DEPTH - GRADIENT_SPAN;
	localparam int DLY_OFS       = STORE_DEPTH - OUTPUT_DELAY;

	localparam int SMP_W   = 16;
	localparam int SUM_W   = 21;
	localparam int IDX_W   = 32;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] OB_FULL = 2'd2;

	typedef logic signed [SMP_W-1:0] smp_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD,
		REG_AVG_LEN,
		REG_PRE,
		REG_POST
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] threshold;
		logic [4:0]         average_length;
		logic [9:0]         pre_samples;
		logic [11:0]        post_samples;
	} cfg_t;

	localparam logic signed [15:0] THRESHOLD_RST = -16'sd100;
	localparam logic [4:0]         AVG_LEN_RST   = 5'd5;
	localparam logic [9:0]         PRE_RST       = 10'd370;
	localparam logic [11:0]        POST_RST      = 12'd740;

	// one accepted sample entering the pipeline
	typedef struct packed {
		smp_t             x;
		logic [IDX_W-1:0] idx;
		logic             grad_en;
		logic             out_en;
		logic [IDX_W-1:0] out_next;
	} issue_t;

	// trigger decision handed to the region stage
	typedef struct packed {
		logic             fire;
		logic [IDX_W-1:0] peak;
		logic             out_en;
		logic [IDX_W-1:0] out_next;
		smp_t             dly;
		logic [IDX_W-1:0] pcnt;
	} peak_t;

	typedef struct packed {
		smp_t             kept_sample;
		logic [IDX_W-1:0] sample_number;
		logic             region_last;
		logic [IDX_W-1:0] peaks_seen;
	} beat_t;

	typedef struct packed {
		logic [1:0] cnt;
	} ob_status_t;

	// wrapped index difference, read as signed
	function automatic logic signed [IDX_W-1:0] sdiff(input logic [IDX_W-1:0] a,
		input logic [IDX_W-1:0] b);
		sdiff = signed'(a - b);
	endfunction

endpackage

[rtl/core/gts_if.sv]
interface gts_in_if;
	import gts_pkg::*;
	logic valid;
	logic ready;
	smp_t adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface gts_out_if;
	import gts_pkg::*;
	logic             valid;
	logic             ready;
	smp_t             kept_sample;
	logic [IDX_W-1:0] sample_number;
	logic             region_last;
	logic [IDX_W-1:0] peaks_seen;

	modport source (output valid, output kept_sample, output sample_number,
		output region_last, output peaks_seen, input ready);
	modport sink (input valid, input kept_sample, input sample_number,
		input region_last, input peaks_seen, output ready);
endinterface

[rtl/core/gradient_trigger_zero_suppress.sv]
// Gradient-trigger zero suppression.
// smp_in takes one signed ADC sample per beat; smp_out gives the kept samples
// with their stream index, an end-of-run flag and the running peak count.
// Thresholds and window lengths sit on the APB port; write them only while idle.
// Throughput: one sample per cycle unless the output buffer is full and stalled.
// For each accepted sample the sample store does one write and two reads
// (delay tap and gradient tap), and the region merge updates its state directly.
// Delay: a kept sample leaves the stream OUTPUT_DELAY samples after it came
// in; the input beat that releases it passes the store read, gradient, decision
// and region merge registers, then waits in the output buffer.
// Reset: registers return to their defaults, no peak, no region, empty delay
// line. No clearing pass: the fill level gates out reads of unwritten places.
// Stall: a two-entry output buffer absorbs results; smp_in stays ready while
// it has room or smp_out drains, so a stall costs nothing until it is full.
`include "assert_macros.svh"

module gradient_trigger_zero_suppress (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gts_pkg::PADDR_W-1:0] paddr,
	input  logic [gts_pkg::PDATA_W-1:0] pwdata,
	output logic [gts_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	gts_in_if.sink                      smp_in,
	gts_out_if.source                   smp_out
);
	import gts_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	logic [ADDR_W-1:0] wp_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [PTR_W-1:0]  old_sum, dly_sum;
	logic [ADDR_W-1:0] old_addr, dly_addr;

	logic       adv;
	logic       in_fire;
	issue_t     iss;
	smp_t       old_smp, dly_smp;
	logic       pk_valid;
	peak_t      pk;
	logic       emit;
	logic       push;
	beat_t      beat;
	ob_status_t ob_st;

	// configuration port: zero-wait APB, write on the access phase
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold      <= THRESHOLD_RST;
			cfg_q.average_length <= AVG_LEN_RST;
			cfg_q.pre_samples    <= PRE_RST;
			cfg_q.post_samples   <= POST_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_THRESHOLD: cfg_q.threshold      <= signed'(pwdata[15:0]);
				REG_AVG_LEN:   cfg_q.average_length <= pwdata[4:0];
				REG_PRE:       cfg_q.pre_samples    <= pwdata[9:0];
				REG_POST:      cfg_q.post_samples   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD: prdata = {16'd0, cfg_q.threshold};
			REG_AVG_LEN:   prdata = {27'd0, cfg_q.average_length};
			REG_PRE:       prdata = {22'd0, cfg_q.pre_samples};
			REG_POST:      prdata = {20'd0, cfg_q.post_samples};
			default:       prdata = '0;
		endcase
	end

	// whole pipeline moves together; only a full, stalled buffer holds it
	assign adv          = (ob_st.cnt != OB_FULL) || smp_out.ready;
	assign smp_in.ready = adv;
	assign in_fire      = smp_in.valid && adv;

	// ring pointer, fill level and stream index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			idx_q  <= '0;
		end else if (in_fire) begin
			wp_q  <= (wp_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			idx_q <= idx_q + 1'b1;
			if (fill_q < FILL_W'(STORE_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// tap addresses: gradient partner and delayed output sample
	always_comb begin
		old_sum = {1'b0, wp_q} + PTR_W'(OLD_OFS);
		dly_sum = {1'b0, wp_q} + PTR_W'(DLY_OFS);
		if (old_sum >= PTR_W'(STORE_DEPTH)) begin
			old_sum = old_sum - PTR_W'(STORE_DEPTH);
		end
		if (dly_sum >= PTR_W'(STORE_DEPTH)) begin
			dly_sum = dly_sum - PTR_W'(STORE_DEPTH);
		end
		old_addr = old_sum[ADDR_W-1:0];
		dly_addr = dly_sum[ADDR_W-1:0];
	end

	always_comb begin
		iss.x        = smp_in.adc_sample;
		iss.idx      = idx_q;
		iss.grad_en  = fill_q >= FILL_W'(GRADIENT_SPAN);
		iss.out_en   = fill_q >= FILL_W'(OUTPUT_DELAY);
		iss.out_next = iss.out_en ? idx_q - IDX_W'(OUTPUT_DELAY) : '0;
	end

	gts_store u_store (
		.clk       (clk),
		.wr_en     (in_fire),
		.wr_addr   (wp_q),
		.wr_data   (smp_in.adc_sample),
		.rd_addr_a (old_addr),
		.rd_addr_b (dly_addr),
		.rd_data_a (old_smp),
		.rd_data_b (dly_smp)
	);

	gts_trigger u_trigger (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.iss_valid (in_fire),
		.iss       (iss),
		.old_smp   (old_smp),
		.dly_smp   (dly_smp),
		.cfg       (cfg_q),
		.pk_valid  (pk_valid),
		.pk        (pk)
	);

	gts_region u_region (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.pk_valid (pk_valid),
		.pk       (pk),
		.cfg      (cfg_q),
		.emit     (emit),
		.beat     (beat)
	);

	assign push = emit && adv;

	gts_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.beat   (beat),
		.out_ch (smp_out),
		.st     (ob_st)
	);

	// a full buffer that is not draining must have stopped the region stage
	`A_IMPL(a_no_overrun, (ob_st.cnt == OB_FULL) && !smp_out.ready, !push, "beat pushed into full buffer")
	// nothing can leave before the delay line has been filled once
	`A_IMPL(a_out_after_fill, smp_out.valid, fill_q >= FILL_W'(OUTPUT_DELAY), "beat before delay filled")
	// the fill level never drops once saturated
	`A_NEXT(a_fill_sticky, fill_q == FILL_W'(STORE_DEPTH), fill_q == FILL_W'(STORE_DEPTH), "fill level dropped")
endmodule

[rtl/core/gts_store.sv]
module gts_store (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [gts_pkg::ADDR_W-1:0] wr_addr,
	input  gts_pkg::smp_t             wr_data,
	input  logic [gts_pkg::ADDR_W-1:0] rd_addr_a,
	input  logic [gts_pkg::ADDR_W-1:0] rd_addr_b,
	output gts_pkg::smp_t             rd_data_a,
	output gts_pkg::smp_t             rd_data_b
);
	import gts_pkg::*;

	smp_t mem [STORE_DEPTH];

	// read-before-write on the same address
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
			mem[wr_addr] <= wr_data;
		end
	end
endmodule

[rtl/core/gts_trigger.sv]
module gts_trigger (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            iss_valid,
	input  gts_pkg::issue_t iss,
	input  gts_pkg::smp_t   old_smp,
	input  gts_pkg::smp_t   dly_smp,
	input  gts_pkg::cfg_t   cfg,
	output logic            pk_valid,
	output gts_pkg::peak_t  pk
);
	import gts_pkg::*;

	logic   v_s1;
	issue_t iss_s1;

	logic signed [SUM_W-1:0] sum_q;
	logic [3:0]              bp_q;
	smp_t                    grad;
	logic signed [SUM_W-1:0] sum_acc;
	logic [4:0]              cnt;
	logic [4:0]              len;
	logic                    close;
	logic signed [21:0]      prod;

	logic                    v_s2;
	logic                    close_s2;
	logic signed [SUM_W-1:0] sum_s2;
	logic signed [SUM_W-1:0] limit_s2;
	logic [4:0]              cnt_s2;
	logic [IDX_W-1:0]        last_s2;
	logic                    oen_s2;
	logic [IDX_W-1:0]        on_s2;
	smp_t                    dly_s2;

	logic             armed_q;
	logic [IDX_W-1:0] peaks_q;
	logic [IDX_W-1:0] peaks_nx;
	logic             above;
	logic             fire;

	// s1: gradient and block accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= iss_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			iss_s1 <= iss;
		end
	end

	assign grad    = iss_s1.x - old_smp;
	assign sum_acc = sum_q + SUM_W'(grad);
	assign cnt     = {1'b0, bp_q} + 5'd1;
	assign prod    = cfg.threshold * $signed({1'b0, cnt});

	always_comb begin
		if (cfg.average_length == 5'd0) begin
			len = 5'd1;
		end else if (cfg.average_length > 5'd16) begin
			len = 5'd16;
		end else begin
			len = cfg.average_length;
		end
	end

	assign close = iss_s1.grad_en && (cnt >= len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			bp_q  <= '0;
		end else if (v_s1 && adv && iss_s1.grad_en) begin
			if (close) begin
				sum_q <= '0;
				bp_q  <= '0;
			end else begin
				sum_q <= sum_acc;
				bp_q  <= cnt[3:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			close_s2 <= close;
			sum_s2   <= sum_acc;
			limit_s2 <= prod[SUM_W-1:0];
			cnt_s2   <= cnt;
			last_s2  <= iss_s1.idx - IDX_W'(GRADIENT_SPAN);
			oen_s2   <= iss_s1.out_en;
			on_s2    <= iss_s1.out_next;
			dly_s2   <= dly_smp;
		end
	end

	// s2: block decision, arming and peak count
	assign above    = sum_s2 > limit_s2;
	assign fire     = close_s2 && (sum_s2 < limit_s2) && !armed_q;
	assign peaks_nx = (fire && (peaks_q != '1)) ? peaks_q + 1'b1 : peaks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			peaks_q <= '0;
		end else if (v_s2 && adv) begin
			peaks_q <= peaks_nx;
			if (close_s2 && above) begin
				armed_q <= 1'b0;
			end else if (fire) begin
				armed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_valid <= 1'b0;
		end else if (adv) begin
			pk_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pk.fire     <= fire;
			pk.peak     <= last_s2 - IDX_W'(cnt_s2 >> 1);
			pk.out_en   <= oen_s2;
			pk.out_next <= on_s2;
			pk.dly      <= dly_s2;
			pk.pcnt     <= peaks_nx;
		end
	end
endmodule

[rtl/core/gts_region.sv]
module gts_region (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           pk_valid,
	input  gts_pkg::peak_t pk,
	input  gts_pkg::cfg_t  cfg,
	output logic           emit,
	output gts_pkg::beat_t beat
);
	import gts_pkg::*;

	logic [IDX_W-1:0] s_raw;
	logic [IDX_W-1:0] s_cl;
	logic [IDX_W-1:0] e_raw;
	logic             add;

	logic             v_s4;
	logic             add_s4;
	logic [IDX_W-1:0] s_s4;
	logic [IDX_W-1:0] e_s4;
	peak_t            pk_s4;

	logic             pv_q, ra_q;
	logic [IDX_W-1:0] ps_q, pe_q, re_q;
	logic             pv_d, ra_d, ra_mid;
	logic [IDX_W-1:0] ps_d, pe_d, re_d;
	logic             last;

	// s3: requested interval, clamped to the output point
	assign s_raw = pk.peak - IDX_W'(cfg.pre_samples);
	assign e_raw = pk.peak + IDX_W'(cfg.post_samples);
	assign s_cl  = (sdiff(s_raw, pk.out_next) < 0) ? pk.out_next : s_raw;
	assign add   = pk.fire && (sdiff(e_raw, s_cl) > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= pk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			add_s4 <= add;
			s_s4   <= s_cl;
			e_s4   <= e_raw;
			pk_s4  <= pk;
		end
	end

	// s4: merge into the active or waiting region, then gate the delayed sample
	always_comb begin
		pv_d   = pv_q;
		ps_d   = ps_q;
		pe_d   = pe_q;
		ra_d   = ra_q;
		re_d   = re_q;
		ra_mid = ra_q;
		last   = 1'b0;
		if (add_s4) begin
			if (pv_q) begin
				if (sdiff(s_s4, pe_q) > 0 || sdiff(e_s4, pe_q) > 0) begin
					pe_d = e_s4;
				end
			end else if (ra_q && sdiff(s_s4, re_q) <= 0) begin
				if (sdiff(e_s4, re_q) > 0) begin
					re_d = e_s4;
				end
			end else begin
				pv_d = 1'b1;
				ps_d = s_s4;
				pe_d = e_s4;
			end
		end
		if (pk_s4.out_en) begin
			if (!ra_d && pv_d && (pk_s4.out_next == ps_d)) begin
				ra_d = 1'b1;
				re_d = pe_d;
				pv_d = 1'b0;
			end
			ra_mid = ra_d;
			if (ra_d) begin
				last = (pk_s4.out_next + 1'b1) == re_d;
				if (last) begin
					ra_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
			ps_q <= '0;
			pe_q <= '0;
			ra_q <= 1'b0;
			re_q <= '0;
		end else if (v_s4 && adv) begin
			pv_q <= pv_d;
			ps_q <= ps_d;
			pe_q <= pe_d;
			ra_q <= ra_d;
			re_q <= re_d;
		end
	end

	assign emit               = v_s4 && pk_s4.out_en && ra_mid;
	assign beat.kept_sample   = pk_s4.dly;
	assign beat.sample_number = pk_s4.out_next;
	assign beat.region_last   = last;
	assign beat.peaks_seen    = pk_s4.pcnt;
endmodule

[rtl/core/gts_outbuf.sv]
module gts_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gts_pkg::beat_t      beat,
	gts_out_if.source           out_ch,
	output gts_pkg::ob_status_t st
);
	import gts_pkg::*;

	beat_t      b0_q, b1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1) begin
				b0_q <= beat;
			end else begin
				b0_q <= b1_q;
			end
			if (push && cnt_q == OB_FULL) begin
				b1_q <= beat;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				b0_q <= beat;
			end else begin
				b1_q <= beat;
			end
		end
	end

	assign out_ch.valid         = cnt_q != 2'd0;
	assign out_ch.kept_sample   = b0_q.kept_sample;
	assign out_ch.sample_number = b0_q.sample_number;
	assign out_ch.region_last   = b0_q.region_last;
	assign out_ch.peaks_seen    = b0_q.peaks_seen;
	assign st.cnt               = cnt_q;
endmodule

[tb/sv/tb_gradient_trigger_zero_suppress.sv]
`timescale 1ns / 100ps

module tb_gradient_trigger_zero_suppress;
	import gts_pkg::*;

	// ---------------------------------------------------------------
	// Clock, reset, register port, streams
	// ---------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	gts_in_if  in_bus();
	gts_out_if out_bus();

	gradient_trigger_zero_suppress dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.smp_in  (in_bus),
		.smp_out (out_bus)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor state: our own copy of the trigger and region logic
	// ---------------------------------------------------------------
	cfg_t        cfg;
	logic [15:0] delay_line [STORE_DEPTH];
	int          wr_ptr = 0;
	int          filled = 0;
	int          grad_acc = 0;     // running gradient sum of the open block
	int          blk_fill = 0;     // gradients already in the open block
	logic [31:0] stream_idx = '0;  // index of the next sample to arrive
	logic [31:0] emit_idx = '0;    // index of the next sample leaving the delay
	logic [31:0] peak_total = '0;
	bit          armed = 1'b0;     // set after a trigger, cleared by a rising block
	bit          run_open = 1'b0;  // a kept run is being emitted
	logic [31:0] run_end = '0;
	bit          wait_valid = 1'b0; // one run waiting for its start
	logic [31:0] wait_start = '0;
	logic [31:0] wait_end = '0;

	beat_t awaited_kept [$];
	smp_t  pending_samples [$];
	int    queued = 0;
	int    bad_count = 0;

	// idle shaping, changed per segment by the stimulus
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int send_wait;
	int take_wait;

	// index distance with wrap, read as signed
	function automatic int wdiff(logic [31:0] a, logic [31:0] b);
		return int'(a - b);
	endfunction

	// Add the window of one peak. Start is raised to the emit point; an empty
	// window is dropped. A waiting run only ever grows its end, so a gap
	// between it and a later window gets kept too.
	task automatic open_window(input logic [31:0] peak);
		logic [31:0] lo;
		logic [31:0] hi;
		lo = peak - {22'd0, cfg.pre_samples};
		hi = peak + {20'd0, cfg.post_samples};
		if (wdiff(lo, emit_idx) < 0)
			lo = emit_idx;
		if (wdiff(hi, lo) <= 0)
			return;
		if (wait_valid) begin
			if (wdiff(lo, wait_end) > 0 || wdiff(hi, wait_end) > 0)
				wait_end = hi;
		end else if (run_open && wdiff(lo, run_end) <= 0) begin
			// overlaps or touches the run in progress: merge
			if (wdiff(hi, run_end) > 0)
				run_end = hi;
		end else begin
			wait_valid = 1'b1;
			wait_start = lo;
			wait_end = hi;
		end
	endtask

	// One accepted sample: gradient, block decision, then the delayed output.
	task automatic predict_kept(input smp_t x);
		logic [15:0] tap_out;
		logic [15:0] tap_old;
		logic [15:0] grad;
		int          len;
		int          cnt;
		int          limit;
		beat_t       b;
		tap_out = delay_line[(wr_ptr + STORE_DEPTH - OUTPUT_DELAY) % STORE_DEPTH];
		if (filled >= GRADIENT_SPAN) begin
			tap_old = delay_line[(wr_ptr + STORE_DEPTH - GRADIENT_SPAN) % STORE_DEPTH];
			len = cfg.average_length;
			if (len < 1)
				len = 1;
			if (len > 16)
				len = 16;
			cnt = (blk_fill & 15) + 1;
			grad = x - tap_old;
			grad_acc += int'($signed(grad));
			// a block left longer than a newly lowered length closes here
			if (cnt >= len) begin
				limit = int'($signed(cfg.threshold)) * cnt;
				if (grad_acc > limit) begin
					armed = 1'b0;
				end else if (grad_acc < limit && !armed) begin
					armed = 1'b1;
					if (peak_total != '1)
						peak_total++;
					open_window(stream_idx - GRADIENT_SPAN - cnt / 2);
				end
				grad_acc = 0;
				blk_fill = 0;
			end else begin
				blk_fill = cnt;
			end
		end
		if (filled >= OUTPUT_DELAY) begin
			if (!run_open && wait_valid && emit_idx == wait_start) begin
				run_open = 1'b1;
				run_end = wait_end;
				wait_valid = 1'b0;
			end
			if (run_open) begin
				b.kept_sample = tap_out;
				b.sample_number = emit_idx;
				b.region_last = (emit_idx + 1 == run_end);
				b.peaks_seen = peak_total;
				awaited_kept.push_back(b);
				if (b.region_last)
					run_open = 1'b0;
			end
			emit_idx++;
		end
		delay_line[wr_ptr] = x;
		wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
		if (filled < STORE_DEPTH)
			filled++;
		stream_idx++;
	endtask

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic note_mismatch(input string what, input logic [31:0] idx,
		input logic [31:0] got, input logic [31:0] want);
		$display("mismatch: %s at sample %0d: got %0h, want %0h", what, idx, got, want);
		bad_count++;
	endtask

	task automatic check_beat(input beat_t got);
		beat_t want;
		if (awaited_kept.size() == 0) begin
			note_mismatch("beat with nothing awaited", got.sample_number,
				32'(got.kept_sample), 0);
			return;
		end
		want = awaited_kept.pop_front();
		if (got.kept_sample !== want.kept_sample)
			note_mismatch("kept_sample", want.sample_number, 32'(got.kept_sample),
				32'(want.kept_sample));
		if (got.sample_number !== want.sample_number)
			note_mismatch("sample_number", want.sample_number, got.sample_number,
				want.sample_number);
		if (got.region_last !== want.region_last)
			note_mismatch("region_last", want.sample_number, {31'd0, got.region_last},
				{31'd0, want.region_last});
		if (got.peaks_seen !== want.peaks_seen)
			note_mismatch("peaks_seen", want.sample_number, got.peaks_seen,
				want.peaks_seen);
	endtask

	// ---------------------------------------------------------------
	// Sample driver: one beat per queue entry, random gap after each
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
			in_bus.adc_sample <= '0;
			send_wait <= 0;
		end else if (!in_bus.valid || in_bus.ready) begin
			if (send_wait != 0) begin
				in_bus.valid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (pending_samples.size() != 0) begin
				// valid stays high across back-to-back beats
				in_bus.valid <= 1'b1;
				in_bus.adc_sample <= pending_samples.pop_front();
				send_wait <= tx_calm ? 0 : $urandom_range(0, 8);
			end else begin
				in_bus.valid <= 1'b0;
			end
		end
	end

	// accepted input beats feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_bus.valid && in_bus.ready)
			predict_kept(in_bus.adc_sample);
	end

	// ---------------------------------------------------------------
	// Result monitor: check each beat, then stall a random while
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		int hold;
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
			take_wait <= 0;
		end else begin
			hold = take_wait;
			if (out_bus.valid && out_bus.ready) begin
				check_beat('{out_bus.kept_sample, out_bus.sample_number,
					out_bus.region_last, out_bus.peaks_seen});
				hold = rx_calm ? 0 : $urandom_range(0, 8);
			end
			if (hold != 0) begin
				out_bus.ready <= 1'b0;
				take_wait <= hold - 1;
			end else begin
				out_bus.ready <= 1'b1;
				take_wait <= 0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Register writes (setup + access), only while the stream is idle
	// ---------------------------------------------------------------
	task automatic set_register(input reg_idx_t which, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_setting(input cfg_t s);
		set_register(REG_THRESHOLD, {16'd0, s.threshold});
		set_register(REG_AVG_LEN, {27'd0, s.average_length});
		set_register(REG_PRE, {22'd0, s.pre_samples});
		set_register(REG_POST, {20'd0, s.post_samples});
		cfg = s;
	endtask

	// Wait for every queued sample to go in and every awaited beat to come
	// out, then let the pipe drain.
	task automatic settle();
		int waited;
		waited = 0;
		while (pending_samples.size() != 0 || in_bus.valid)
			@(negedge clk);
		while (awaited_kept.size() != 0 && waited < 4000) begin
			@(negedge clk);
			waited++;
		end
		if (awaited_kept.size() != 0) begin
			note_mismatch("beats never delivered", awaited_kept[0].sample_number,
				awaited_kept.size(), 0);
			awaited_kept.delete();
		end
		repeat (16) @(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Stimulus shapes
	// ---------------------------------------------------------------
	task automatic queue_level(input int level, input int jit, input int n);
		repeat (n) begin
			pending_samples.push_back(smp_t'(level + int'($urandom_range(0, 2 * jit)) - jit));
			queued++;
		end
	endtask

	// Linear ramp. Slope num/den per sample gives a flat gradient of
	// 100*num/den, so a ramp can land exactly on the threshold (no change).
	task automatic queue_ramp();
		int start;
		int num;
		int den;
		int dir;
		int n;
		start = int'($urandom_range(0, 40000)) - 20000;
		num = $urandom_range(0, 4);
		den = $urandom_range(1, 2);
		dir = ($urandom_range(0, 3) == 0) ? 1 : -1;
		n = $urandom_range(110, 260);
		for (int i = 0; i < n; i++) begin
			pending_samples.push_back(smp_t'(start + dir * (i * num / den)));
			queued++;
		end
	endtask

	// Mostly falling steps (they trigger, and the next baseline re-arms),
	// plus ramps, raw noise and full-scale toggling that wraps the gradient.
	task automatic queue_segment();
		int pick;
		int n;
		int base;
		pick = $urandom_range(0, 99);
		tx_calm = ($urandom_range(0, 4) == 0);
		rx_calm = ($urandom_range(0, 4) == 0);
		if (pick < 50) begin
			base = int'($urandom_range(0, 40000)) - 20000;
			n = $urandom_range(0, 30);
			queue_level(base, n, $urandom_range(5, 160));
			queue_level(base - int'($urandom_range(150, 12000)), n, $urandom_range(3, 220));
		end else if (pick < 70) begin
			queue_ramp();
		end else if (pick < 90) begin
			n = $urandom_range(1, 40);
			repeat (n) begin
				pending_samples.push_back(smp_t'($urandom));
				queued++;
			end
		end else begin
			n = $urandom_range(2, 30);
			for (int i = 0; i < n; i++) begin
				pending_samples.push_back(i[0] ? 16'sh7FFF : 16'sh8000);
				queued++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		cfg_t plan [8];
		smp_t corner_vals [9];
		int   phase;
		int   made;
		int   first;
		int   quota;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg = '{THRESHOLD_RST, AVG_LEN_RST, PRE_RST, POST_RST};

		// settings visited in turn after the reset values
		plan[0] = '{16'sh8000, 5'd16, 10'd0, 12'd1};      // lowest threshold, longest block
		plan[1] = '{16'sh0000, 5'd1, 10'd896, 12'd4095};  // zero threshold, widest window
		plan[2] = '{-16'sd300, 5'd0, 10'd100, 12'd200};   // length 0 behaves as 1
		plan[3] = '{16'sh7FFF, 5'd31, 10'd512, 12'd50};   // positive threshold, length clipped
		plan[4] = '{-16'sd50, 5'd3, 10'd1023, 12'd0};     // post 0: window ends just before the peak
		plan[5] = '{-16'sd200, 5'd8, 10'd1023, 12'd300};  // start lands behind emit point
		plan[6] = '{-16'sd150, 5'd4, 10'd40, 12'd60};     // short windows with gaps
		plan[7] = '{THRESHOLD_RST, AVG_LEN_RST, PRE_RST, POST_RST};

		corner_vals = '{16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF, 16'sh8000,
			16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: full-scale and bit patterns, then a high plateau so the
		// first drop puts a peak near index 0 and its window start clamps
		foreach (corner_vals[i]) begin
			pending_samples.push_back(corner_vals[i]);
			queued++;
		end
		queue_level(24000, 0, 16);

		// random phases; the first one is long and fills most of the delay line
		phase = 0;
		made = 0;
		while (made < 1100 && phase < 40) begin
			if (phase != 0)
				load_setting(plan[(phase - 1) % 8]);
			first = queued;
			quota = (phase == 0) ? 600 : 70;
			while (queued - first < quota) begin
				queue_segment();
				while (pending_samples.size() > 16)
					@(negedge clk);
			end
			// sender holds off here until every awaited beat is back
			settle();
			made += queued - first;
			phase++;
		end

		if (bad_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
